FILE: hw/rtl/mrt_pkg.sv
package mrt_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [31:0] TIMEOUT_RST = 32'd120000;
  localparam logic [7:0]  MAX_HOPS_RST = 8'd48;

  localparam logic [0:0] REG_TIMEOUT  = 1'b0;
  localparam logic [0:0] REG_MAX_HOPS = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [31:0] node;
    logic [31:0] hop;
    logic [7:0]  hops;
    logic [31:0] stamp;
    logic        mark;
  } entry_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_idx;
    entry_t           push_data;
    logic             kill_en;
    logic [31:0]      kill_id;
    logic [CNT_W-1:0] cnt;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/mesh_route_table_unit.sv
// Route table of up to 32 entries kept oldest first in a row of cells that
// behaves as a queue. Add, lookup and read walk the table once, sweep twice,
// by popping the head entry and pushing it, changed or not, back at the tail
// unless it is dropped, one entry per cycle; an add may then append an entry.
// A sweep marks stale entries and the subs of dropped direct nodes, then compacts.
// One item is worked on at a time; s_axis_tready is high while the unit is
// idle. Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i
// (0 timeout_ms, 1 max_hops); the user must write them only while no item is
// in flight, as the unit itself does not enforce this.
module mesh_route_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // node_id, first_hop, hop_count, entry_index, now_ms, 2 bits zero
  input  logic [111:0]  s_axis_tdata,
  // command
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_node_id, out_first_hop, out_hop_count, entry_count, 1 bit zero
  output logic [79:0]   m_axis_tdata,
  // ok
  output logic [0:0]    m_axis_tuser,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_addr_i,
  input  logic [31:0]   cfg_wdata_i
);
  import mrt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PASS1, ST_PASS2, ST_APPEND, ST_DONE
  } state_e;

  state_e           state_q;
  cmd_e             cmd_q;
  logic [31:0]      id_q, hop_q, now_q;
  logic [7:0]       hops_q;
  logic [5:0]       idx_q;
  logic [CNT_W-1:0] cnt_q, cnt_d, n_q, step_q;
  logic             found_q, append_q, ok_q;
  logic [31:0]      r_node_q, r_hop_q;
  logic [7:0]       r_hops_q;
  logic [31:0]      timeout_q;
  logic [7:0]       max_hops_q;
  logic             m_valid_q;
  logic [79:0]      m_data_q;
  logic             m_ok_q;

  cell_ctrl_t ctrl;
  entry_t     ents [TABLE_DEPTH];
  entry_t     head;
  logic       walking, last_step, stale, match;
  logic [31:0] age;

  assign head = ents[0];
  assign walking = ((state_q == ST_PASS1) || (state_q == ST_PASS2)) && (step_q != n_q);
  assign last_step = (step_q == n_q);
  assign age = now_q - head.stamp;
  assign stale = (age > timeout_q) || (head.hops > max_hops_q);
  assign match = !found_q && (head.node == id_q);

  always_comb begin
    ctrl = '0;
    ctrl.cnt = cnt_q;
    ctrl.push_data = head;
    if (walking) begin
      ctrl.pop = 1'b1;
      ctrl.push = 1'b1;
      if (state_q == ST_PASS2) begin
        ctrl.push = !head.mark;
      end else begin
        case (cmd_q)
          CMD_ADD: begin
            if (match && (head.hop == 32'd0)) begin
              if (hop_q == 32'd0) begin
                ctrl.push_data.stamp = now_q;
              end
            end else if (match && !((hop_q != 32'd0) && (head.hops < hops_q))) begin
              ctrl.push = 1'b0;
            end
          end
          CMD_SWEEP: begin
            ctrl.push_data.mark = head.mark | stale;
            if (stale && (head.hop == 32'd0)) begin
              ctrl.kill_en = 1'b1;
              ctrl.kill_id = head.node;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (state_q == ST_APPEND) begin
      ctrl.pop = (cnt_q == CNT_W'(TABLE_DEPTH));
      ctrl.push = 1'b1;
      ctrl.push_data.node = id_q;
      ctrl.push_data.hop = hop_q;
      ctrl.push_data.hops = hops_q;
      ctrl.push_data.stamp = now_q;
      ctrl.push_data.mark = 1'b0;
    end
    ctrl.push_idx = IDX_W'(cnt_q - CNT_W'(ctrl.pop));
    cnt_d = cnt_q - CNT_W'(ctrl.pop) + CNT_W'(ctrl.push);
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t nxt;
    if (k == TABLE_DEPTH - 1) begin : g_last
      assign nxt = ents[k];
    end else begin : g_mid
      assign nxt = ents[k + 1];
    end
    mrt_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(k)),
      .ctrl_i     (ctrl),
      .nxt_i      (nxt),
      .ent_o      (ents[k])
    );
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;
  assign m_axis_tuser = m_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      timeout_q <= TIMEOUT_RST;
      max_hops_q <= MAX_HOPS_RST;
      m_valid_q <= 1'b0;
      cmd_q <= CMD_ADD;
      n_q <= '0;
      step_q <= '0;
      found_q <= 1'b0;
      append_q <= 1'b0;
      ok_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TIMEOUT:  timeout_q <= cfg_wdata_i;
          REG_MAX_HOPS: max_hops_q <= cfg_wdata_i[7:0];
          default: begin
          end
        endcase
      end
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q <= cmd_e'(s_axis_tuser);
            id_q <= s_axis_tdata[31:0];
            hop_q <= s_axis_tdata[63:32];
            hops_q <= s_axis_tdata[71:64];
            idx_q <= s_axis_tdata[77:72];
            now_q <= s_axis_tdata[109:78];
            n_q <= cnt_q;
            step_q <= '0;
            found_q <= 1'b0;
            append_q <= 1'b0;
            ok_q <= 1'b0;
            r_node_q <= '0;
            r_hop_q <= '0;
            r_hops_q <= '0;
            state_q <= ST_PASS1;
          end
        end
        ST_PASS1: begin
          if (last_step) begin
            if (cmd_q == CMD_SWEEP) begin
              n_q <= cnt_q;
              step_q <= '0;
              state_q <= ST_PASS2;
            end else if ((cmd_q == CMD_ADD) && (id_q != 32'd0) && (append_q || !found_q)) begin
              state_q <= ST_APPEND;
            end else begin
              state_q <= ST_DONE;
            end
          end else begin
            step_q <= step_q + CNT_W'(1);
            case (cmd_q)
              CMD_ADD: begin
                if (match) begin
                  found_q <= 1'b1;
                  append_q <= !ctrl.push;
                end
              end
              CMD_LOOKUP: begin
                if (match) begin
                  found_q <= 1'b1;
                  ok_q <= 1'b1;
                  r_node_q <= head.node;
                  r_hop_q <= head.hop;
                  r_hops_q <= head.hops;
                end
              end
              CMD_READ: begin
                if ({1'b0, idx_q} == 7'(step_q)) begin
                  ok_q <= 1'b1;
                  r_node_q <= head.node;
                  r_hop_q <= head.hop;
                  r_hops_q <= head.hops;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_PASS2: begin
          if (last_step) begin
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q + CNT_W'(1);
            if (head.mark) begin
              ok_q <= 1'b1;
            end
          end
        end
        ST_APPEND: begin
          ok_q <= 1'b1;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_ok_q <= ok_q;
            m_data_q <= {1'b0, 7'(cnt_q), r_hops_q, r_hop_q, r_node_q};
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> (!ctrl.pop && !ctrl.push))
    else $error("cells move while no command runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |-> ((cnt_q - CNT_W'(ctrl.pop)) < CNT_W'(TABLE_DEPTH)))
    else $error("push beyond table end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS2 && !last_step) |=> (cnt_q <= $past(cnt_q)))
    else $error("compaction grew the table");

endmodule

FILE: hw/rtl/mrt_cell.sv
module mrt_cell (
  input  logic                      clk_i,
  input  logic [mrt_pkg::IDX_W-1:0] cell_idx_i,
  input  mrt_pkg::cell_ctrl_t       ctrl_i,
  input  mrt_pkg::entry_t           nxt_i,
  output mrt_pkg::entry_t           ent_o
);
  import mrt_pkg::*;

  entry_t entry_q, entry_d;
  logic   hit;

  assign hit = ctrl_i.kill_en && (entry_q.hop != 32'd0) && (entry_q.hop == ctrl_i.kill_id) &&
               ({1'b0, cell_idx_i} < ctrl_i.cnt);

  always_comb begin
    ent_o = entry_q;
    ent_o.mark = entry_q.mark | hit;
  end

  always_comb begin
    if (ctrl_i.push && (ctrl_i.push_idx == cell_idx_i)) begin
      entry_d = ctrl_i.push_data;
    end else if (ctrl_i.pop) begin
      entry_d = nxt_i;
    end else begin
      entry_d = ent_o;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: verif/mesh_route_table_checker.sv
module mesh_route_table_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // node_id, first_hop, hop_count, entry_index, now_ms, 2 bits zero
  input  logic [111:0] s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_node_id, out_first_hop, out_hop_count, entry_count, 1 bit zero
  input  logic [79:0]  m_axis_tdata,
  // ok
  input  logic [0:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  output int           errors_o,
  output int           pending_o,
  output int           replies_o,
  output int           hits_o
);
  import mrt_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [31:0] node;
    logic [31:0] hop;
    logic [7:0]  hops;
    logic [6:0]  count;
  } route_reply_t;

  logic [31:0] rt_node [TABLE_DEPTH];
  logic [31:0] rt_hop [TABLE_DEPTH];
  logic [7:0]  rt_hops [TABLE_DEPTH];
  logic [31:0] rt_stamp [TABLE_DEPTH];
  int unsigned rt_used;
  logic [31:0] timeout_q;
  logic [7:0]  max_hops_q;
  route_reply_t reply_q[$];

  initial begin
    errors_o = 0;
    pending_o = 0;
    replies_o = 0;
    hits_o = 0;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (errors_o < 40) begin
      $display("mismatch on %s: got %h, want %h", what, got, want);
    end
    errors_o++;
  endtask

  function automatic void drop_at(int unsigned pos);
    for (int unsigned k = pos; k + 1 < rt_used; k++) begin
      rt_node[k] = rt_node[k+1];
      rt_hop[k] = rt_hop[k+1];
      rt_hops[k] = rt_hops[k+1];
      rt_stamp[k] = rt_stamp[k+1];
    end
    rt_used--;
  endfunction

  function automatic logic add_route(logic [31:0] id, logic [31:0] hop, logic [7:0] hops,
                                     logic [31:0] now);
    if (id == 0) return 1'b0;
    for (int unsigned k = 0; k < rt_used; k++) begin
      if (rt_node[k] == id) begin
        if (rt_hop[k] == 0) begin
          if (hop == 0) rt_stamp[k] = now;
          return 1'b0;
        end
        if (hop != 0 && rt_hops[k] < hops) return 1'b0;
        drop_at(k);
        break;
      end
    end
    if (rt_used >= TABLE_DEPTH) drop_at(0);
    rt_node[rt_used] = id;
    rt_hop[rt_used] = hop;
    rt_hops[rt_used] = hops;
    rt_stamp[rt_used] = now;
    rt_used++;
    return 1'b1;
  endfunction

  function automatic logic sweep_routes(logic [31:0] now);
    logic doomed [TABLE_DEPTH];
    logic [31:0] age;
    int unsigned w;
    logic any;
    any = 1'b0;
    w = 0;
    for (int unsigned k = 0; k < rt_used; k++) begin
      age = now - rt_stamp[k];
      doomed[k] = (age > timeout_q) || (rt_hops[k] > max_hops_q);
    end
    for (int unsigned k = 0; k < rt_used; k++) begin
      if (doomed[k] && rt_hop[k] == 0) begin
        for (int unsigned j = 0; j < rt_used; j++) begin
          if (rt_hop[j] != 0 && rt_hop[j] == rt_node[k]) doomed[j] = 1'b1;
        end
      end
    end
    for (int unsigned k = 0; k < rt_used; k++) begin
      if (doomed[k]) begin
        any = 1'b1;
      end else begin
        rt_node[w] = rt_node[k];
        rt_hop[w] = rt_hop[k];
        rt_hops[w] = rt_hops[k];
        rt_stamp[w] = rt_stamp[k];
        w++;
      end
    end
    rt_used = w;
    return any;
  endfunction

  function automatic route_reply_t predict_reply(cmd_e cmd, logic [31:0] id, logic [31:0] hop,
                                                 logic [7:0] hops, logic [5:0] idx,
                                                 logic [31:0] now);
    route_reply_t r;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        r.ok = add_route(id, hop, hops, now);
      end
      CMD_LOOKUP: begin
        for (int unsigned k = 0; k < rt_used; k++) begin
          if (rt_node[k] == id) begin
            r.ok = 1'b1;
            r.node = rt_node[k];
            r.hop = rt_hop[k];
            r.hops = rt_hops[k];
            break;
          end
        end
      end
      CMD_SWEEP: begin
        r.ok = sweep_routes(now);
      end
      default: begin
        if (idx < rt_used && idx < TABLE_DEPTH) begin
          r.ok = 1'b1;
          r.node = rt_node[idx];
          r.hop = rt_hop[idx];
          r.hops = rt_hops[idx];
        end
      end
    endcase
    r.count = rt_used[6:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    route_reply_t want;
    if (!rst_ni) begin
      rt_used = 0;
      timeout_q = TIMEOUT_RST;
      max_hops_q = MAX_HOPS_RST;
      reply_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_TIMEOUT) timeout_q = cfg_wdata_i;
        else max_hops_q = cfg_wdata_i[7:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        replies_o++;
        if (reply_q.size() == 0) begin
          report("unexpected item", {31'd0, m_axis_tuser}, 32'd0);
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tuser[0] !== want.ok) report("ok", {31'd0, m_axis_tuser}, {31'd0, want.ok});
          if (m_axis_tdata[31:0] !== want.node) report("node", m_axis_tdata[31:0], want.node);
          if (m_axis_tdata[63:32] !== want.hop) report("first hop", m_axis_tdata[63:32], want.hop);
          if (m_axis_tdata[71:64] !== want.hops) begin
            report("hop count", {24'd0, m_axis_tdata[71:64]}, {24'd0, want.hops});
          end
          if (m_axis_tdata[78:72] !== want.count) begin
            report("entry count", {25'd0, m_axis_tdata[78:72]}, {25'd0, want.count});
          end
          if (want.ok) hits_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        reply_q.push_back(predict_reply(cmd_e'(s_axis_tuser), s_axis_tdata[31:0],
                                        s_axis_tdata[63:32], s_axis_tdata[71:64],
                                        s_axis_tdata[77:72], s_axis_tdata[109:78]));
      end
    end
    pending_o = reply_q.size();
  end

endmodule

FILE: verif/testbench.sv
module testbench;
  import mrt_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [79:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_we_i;
  logic [0:0]   cfg_addr_i;
  logic [31:0]  cfg_wdata_i;

  int errors;
  int pending;
  int replies;
  int hits;
  int sent;
  int cfg_writes;
  int stall_count;
  logic quiet;
  logic hold_req;
  logic [31:0] clock_ms;

  mesh_route_table_unit dut (.*);

  mesh_route_table_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending), .replies_o(replies), .hits_o(hits)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_ADD;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = REG_TIMEOUT;
    cfg_wdata_i = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    cfg_writes = 0;
    stall_count = 0;
    clock_ms = 32'd1000;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_item(cmd_e cmd, logic [31:0] id, logic [31:0] hop, logic [7:0] hops,
                           logic [5:0] idx, logic [31:0] now);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tuser = cmd;
    s_axis_tdata = {2'b00, now, idx, hops, hop, id};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] addr, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [31:0] pick_node();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic random_item();
    cmd_e cmd;
    logic [31:0] id;
    logic [31:0] hop;
    logic [7:0] hops;
    logic [5:0] idx;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) cmd = CMD_ADD;
    else if (roll < 65) cmd = CMD_LOOKUP;
    else if (roll < 75) cmd = CMD_SWEEP;
    else cmd = CMD_READ;
    id = ($urandom_range(0, 30) == 0) ? 32'd0 : pick_node();
    hop = ($urandom_range(0, 9) < 4) ? 32'd0 : pick_node();
    hops = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 8));
    idx = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 33));
    if ($urandom_range(0, 40) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 3000);
    send_item(cmd, id, hop, hops, idx, clock_ms);
  endtask

  initial begin
    logic [31:0] timeouts [5];
    logic [7:0] hop_limits [5];
    timeouts = '{32'd4000, 32'd0, 32'hFFFF_FFFF, 32'd9000, 32'd120000};
    hop_limits = '{8'd3, 8'd255, 8'd0, 8'd6, 8'd48};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, reset register values
    send_item(CMD_ADD, 32'd0, 32'd0, 8'd1, 6'd0, 32'd100);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 32'd0, 8'd1, 6'd0, 32'd100);
    send_item(CMD_ADD, 32'd5, 32'hFFFF_FFFF, 8'd4, 6'd0, 32'd200);
    send_item(CMD_ADD, 32'd5, 32'd7, 8'd9, 6'd0, 32'd300);
    send_item(CMD_ADD, 32'd5, 32'd7, 8'd2, 6'd0, 32'd400);
    send_item(CMD_ADD, 32'd5, 32'd0, 8'd1, 6'd0, 32'd500);
    send_item(CMD_ADD, 32'd5, 32'd0, 8'd1, 6'd0, 32'd600);
    send_item(CMD_ADD, 32'd5, 32'd9, 8'd0, 6'd0, 32'd700);
    send_item(CMD_ADD, 32'd6, 32'd5, 8'd255, 6'd0, 32'd800);
    send_item(CMD_ADD, 32'd8, 32'd5, 8'd2, 6'd0, 32'd900);
    send_item(CMD_LOOKUP, 32'd5, 32'd0, 8'd0, 6'd0, 32'd900);
    send_item(CMD_LOOKUP, 32'd77, 32'd0, 8'd0, 6'd0, 32'd900);
    send_item(CMD_LOOKUP, 32'd0, 32'd0, 8'd0, 6'd0, 32'd900);
    send_item(CMD_READ, 32'd0, 32'd0, 8'd0, 6'd0, 32'd900);
    send_item(CMD_READ, 32'd0, 32'd0, 8'd0, 6'd3, 32'd900);
    send_item(CMD_READ, 32'd0, 32'd0, 8'd0, 6'd63, 32'd900);
    send_item(CMD_SWEEP, 32'd0, 32'd0, 8'd0, 6'd0, 32'd1000);
    send_item(CMD_ADD, 32'd5, 32'd0, 8'd1, 6'd0, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 32'd12, 32'd5, 8'd2, 6'd0, 32'hFFFF_FFFF);
    send_item(CMD_SWEEP, 32'd0, 32'd0, 8'd0, 6'd0, 32'd200000);
    send_item(CMD_READ, 32'd0, 32'd0, 8'd0, 6'd0, 32'd0);
    settle();

    write_reg(REG_MAX_HOPS, 32'd0);
    send_item(CMD_ADD, 32'd3, 32'd0, 8'd0, 6'd0, 32'd0);
    send_item(CMD_ADD, 32'd4, 32'd3, 8'd1, 6'd0, 32'd0);
    send_item(CMD_SWEEP, 32'd0, 32'd0, 8'd0, 6'd0, 32'd0);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      write_reg(REG_TIMEOUT, timeouts[phase]);
      write_reg(REG_MAX_HOPS, {24'd0, hop_limits[phase]});
      quiet = (phase == 4);
      for (int n = 0; n < 95; n++) begin
        if (phase == 1 && n == 10) begin
          hold_req = 1'b1;
        end
        if (phase == 2 && n == 50) begin
          @(negedge clk_i);
          s_axis_tvalid = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        random_item();
      end
      settle();
    end

    $display("covered %0d items with %0d register writes over six settings", sent, cfg_writes);
    $display("%0d replies checked, %0d with ok set", replies, hits);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
